// ----- rtl/core/osm_pkg.sv -----
package osm_pkg;

    // Default number of cells in the chain
    localparam int CAPACITY = 256;

    // Width of a stored value
    localparam int DATA_W = 32;

    // Operation codes
    localparam logic OP_ADD = 1'b0;
    localparam logic OP_GET = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    // Insert command broadcast to every cell
    typedef struct packed {
        logic                     ins_en;
        logic signed [DATA_W-1:0] ins_value;
    } cell_ctrl_t;

endpackage

// ----- rtl/core/osm_cell.sv -----
module osm_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 9
) (
    input  logic                              clk,
    input  osm_pkg::cell_ctrl_t               ctrl,
    input  logic [CNT_W-1:0]                  count,
    input  logic [CNT_W-1:0]                  rank_idx,
    input  logic signed [osm_pkg::DATA_W-1:0] prev_value,
    input  logic                              prev_gt,
    output logic signed [osm_pkg::DATA_W-1:0] cell_value,
    output logic                              gt,
    output logic [osm_pkg::DATA_W-1:0]        read_word
);

    localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

    logic signed [osm_pkg::DATA_W-1:0] value_reg;
    logic signed [osm_pkg::DATA_W-1:0] value_next;
    logic                              empty;

    // Flag this cell as a shift target: empty, or holding a larger value
    assign empty = (MY_IDX >= count);
    assign gt    = empty || (value_reg > ctrl.ins_value);

    // Take the neighbor's value if it moves too, else take the new value
    always_comb
    begin
        value_next = value_reg;
        if (ctrl.ins_en && gt)
        begin
            value_next = prev_gt ? prev_value : ctrl.ins_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign cell_value = value_reg;

    // Drive the read bus only when this cell holds the requested rank
    assign read_word = (rank_idx == MY_IDX) ? value_reg : '0;

endmodule

// ----- rtl/core/order_statistic_multiset.sv -----
// Channel  | handshake             | beat fields
// ---------+-----------------------+----------------------------------------
// in       | in_valid / in_stall   | operation, value, rank
// out      | out_valid / out_stall | result_value, status, stored_count
//
// One item per cycle while in_stall is low: an add shifts the compare-and-shift
// cell chain at once, a get selects one cell through a one-hot mux over the chain.
// The result is registered into an output register on acceptance.
// in_stall rises only while a result waits in that register and out_stall is high.
// rst_n clears the count and the output valid; cell contents are left as is.
module order_statistic_multiset #(
    parameter int CAPACITY = osm_pkg::CAPACITY,
    localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              operation,
    input  logic signed [osm_pkg::DATA_W-1:0] value,
    input  logic [CNT_W-1:0]                  rank,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [osm_pkg::DATA_W-1:0] result_value,
    output logic [1:0]                        status,
    output logic [CNT_W-1:0]                  stored_count
);

    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    logic [CNT_W-1:0]                  count_reg;
    logic [CNT_W-1:0]                  count_next;
    logic                              out_valid_reg;
    logic                              out_valid_next;
    logic signed [osm_pkg::DATA_W-1:0] result_value_reg;
    logic signed [osm_pkg::DATA_W-1:0] result_value_next;
    logic [1:0]                        status_reg;
    logic [1:0]                        status_next;
    logic [CNT_W-1:0]                  stored_count_reg;
    logic [CNT_W-1:0]                  stored_count_next;

    logic                              in_fire;
    logic                              is_add;
    logic                              full;
    logic                              rank_ok;
    logic [CNT_W-1:0]                  rank_idx;
    logic [osm_pkg::DATA_W-1:0]        sel_word;
    osm_pkg::cell_ctrl_t               ctrl;

    logic signed [osm_pkg::DATA_W-1:0] cell_value [CAPACITY];
    logic [CAPACITY-1:0]               cell_gt;
    logic [osm_pkg::DATA_W-1:0]        read_word  [CAPACITY];

    // Handshake: hold input while a result waits and the sink stalls
    assign in_stall = out_valid_reg && out_stall;
    assign in_fire  = in_valid && !in_stall;

    // Decode the beat
    assign is_add   = (operation == osm_pkg::OP_ADD);
    assign full     = (count_reg >= CAP_CNT);
    assign rank_ok  = (rank != '0) && (rank <= count_reg);
    assign rank_idx = rank - CNT_W'(1);

    assign ctrl.ins_en    = in_fire && is_add && !full;
    assign ctrl.ins_value = value;

    // Build the cell chain
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_head
                osm_cell #(
                    .IDX   (gi),
                    .CNT_W (CNT_W)
                ) u_cell (
                    .clk        (clk),
                    .ctrl       (ctrl),
                    .count      (count_reg),
                    .rank_idx   (rank_idx),
                    .prev_value ('0),
                    .prev_gt    (1'b0),
                    .cell_value (cell_value[gi]),
                    .gt         (cell_gt[gi]),
                    .read_word  (read_word[gi])
                );
            end
            else
            begin : g_body
                osm_cell #(
                    .IDX   (gi),
                    .CNT_W (CNT_W)
                ) u_cell (
                    .clk        (clk),
                    .ctrl       (ctrl),
                    .count      (count_reg),
                    .rank_idx   (rank_idx),
                    .prev_value (cell_value[gi-1]),
                    .prev_gt    (cell_gt[gi-1]),
                    .cell_value (cell_value[gi]),
                    .gt         (cell_gt[gi]),
                    .read_word  (read_word[gi])
                );
            end
        end
    endgenerate

    // Merge the one-hot read bus
    always_comb
    begin
        sel_word = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            sel_word = sel_word | read_word[i];
        end
    end

    // Advance the count on a successful add
    assign count_next = count_reg + CNT_W'(ctrl.ins_en);

    // Form the result beat
    always_comb
    begin
        result_value_next = result_value_reg;
        status_next       = status_reg;
        stored_count_next = stored_count_reg;
        if (in_fire)
        begin
            result_value_next = '0;
            status_next       = osm_pkg::ST_OK;
            stored_count_next = count_next;
            if (is_add)
            begin
                if (full)
                begin
                    status_next = osm_pkg::ST_FULL;
                end
            end
            else if (rank_ok)
            begin
                result_value_next = sel_word;
            end
            else
            begin
                status_next = osm_pkg::ST_RANGE;
            end
        end
    end

    // Keep the output beat until the sink takes it
    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (in_fire)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_value_reg <= result_value_next;
        status_reg       <= status_next;
        stored_count_reg <= stored_count_next;
    end

    assign out_valid    = out_valid_reg;
    assign result_value = result_value_reg;
    assign status       = status_reg;
    assign stored_count = stored_count_reg;

endmodule
